// File: src/cws_pkg.sv
// shared types, codes and constants for the congestion window sender
`timescale 1ns / 1ps
package cws_pkg;

  localparam int QUEUE_DEPTH_DEF = 10;
  localparam int CQ_DEPTH        = 2;
  localparam int CFG_AW          = 4;

  localparam logic [7:0]  WIN_MAX     = 8'd255;
  localparam logic [15:0] BACKLOG_MAX = 16'hFFFF;

  localparam logic [7:0]  SSTHRESH_RST  = 8'd10;
  localparam logic [15:0] TIMEOUT_RST   = 16'd5;
  localparam logic [3:0]  DUP_LIMIT_RST = 4'd3;

  // input opcodes
  localparam logic [1:0] OP_MAKE = 2'd0;
  localparam logic [1:0] OP_SEND = 2'd1;
  localparam logic [1:0] OP_ACK  = 2'd2;

  // result event codes
  localparam logic [2:0] EV_NONE      = 3'd0;
  localparam logic [2:0] EV_QUEUED    = 3'd1;
  localparam logic [2:0] EV_BACKLOG   = 3'd2;
  localparam logic [2:0] EV_ACK_OK    = 3'd3;
  localparam logic [2:0] EV_TIMEOUT   = 3'd4;
  localparam logic [2:0] EV_STALE     = 3'd5;
  localparam logic [2:0] EV_INVALID   = 3'd6;

  // result kinds
  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_PAGE   = 1'b1;

  // register indexes
  localparam logic [1:0] REG_SSTHRESH  = 2'd0;
  localparam logic [1:0] REG_TIMEOUT   = 2'd1;
  localparam logic [1:0] REG_DUP_LIMIT = 2'd2;

  typedef enum logic [1:0] {
    CMD_MAKE,
    CMD_SEND,
    CMD_ACK,
    CMD_NOP
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t     op;
    logic [31:0] ack_num;
    logic [31:0] now;
  } cmd_t;

  typedef struct packed {
    logic        kind;
    logic [31:0] page_num;
    logic [7:0]  window;
    logic [2:0]  event_res;
    logic        halved;
    logic [3:0]  queue_count;
    logic        last;
  } res_t;

  typedef struct packed {
    logic [7:0]  ssthresh;
    logic [15:0] timeout;
    logic [3:0]  dup_limit;
  } cfg_t;

  typedef enum logic {
    B_IDLE,
    B_SEND
  } bst_t;

endpackage

// File: src/cws_cfg.sv
// configuration registers behind the apb-style port
`timescale 1ns / 1ps
module cws_cfg (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [cws_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  output cws_pkg::cfg_t              cfg
);
  import cws_pkg::*;

  cfg_t       cfg_r;
  cfg_t       cfg_nxt;
  logic [1:0] idx;
  logic       wr_en;

  assign pready = 1'b1;
  assign idx    = paddr[CFG_AW-1:2];
  assign wr_en  = psel && penable && pwrite && pready;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        REG_SSTHRESH:  cfg_nxt.ssthresh  = pwdata[7:0];
        REG_TIMEOUT:   cfg_nxt.timeout   = pwdata[15:0];
        REG_DUP_LIMIT: cfg_nxt.dup_limit = pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_SSTHRESH:  prdata = {24'd0, cfg_r.ssthresh};
      REG_TIMEOUT:   prdata = {16'd0, cfg_r.timeout};
      REG_DUP_LIMIT: prdata = {28'd0, cfg_r.dup_limit};
      default:       prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ssthresh  <= SSTHRESH_RST;
      cfg_r.timeout   <= TIMEOUT_RST;
      cfg_r.dup_limit <= DUP_LIMIT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// File: src/cws_front.sv
// front end: accepts items, decodes the opcode and queues commands
`timescale 1ns / 1ps
module cws_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  output logic          full,
  input  logic [1:0]    in_opcode,
  input  logic [31:0]   in_ack_num,
  input  logic [31:0]   in_now,
  output logic          cmd_valid,
  output cws_pkg::cmd_t cmd,
  input  logic          cmd_take
);
  import cws_pkg::*;

  localparam int PW = (CQ_DEPTH > 1) ? $clog2(CQ_DEPTH) : 1;
  localparam int NW = $clog2(CQ_DEPTH + 1);

  cmd_t          mem_r [CQ_DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [NW-1:0] count_r, count_nxt;
  logic          wr_en;
  logic          rd_en;
  cmd_t          new_cmd;

  function automatic cmd_op_t classify(input logic [1:0] opc);
    cmd_op_t res;
    unique case (opc)
      OP_MAKE: res = CMD_MAKE;
      OP_SEND: res = CMD_SEND;
      OP_ACK:  res = CMD_ACK;
      default: res = CMD_NOP;
    endcase
    return res;
  endfunction

  assign full      = (count_r == NW'(CQ_DEPTH));
  assign cmd_valid = (count_r != '0);
  assign cmd       = mem_r[rd_ptr_r];
  assign wr_en     = push && !full;
  assign rd_en     = cmd_take && cmd_valid;

  always_comb begin
    new_cmd.op      = classify(in_opcode);
    new_cmd.ack_num = in_ack_num;
    new_cmd.now     = in_now;
  end

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (wr_en) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(CQ_DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (rd_en) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(CQ_DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (wr_en && !rd_en) begin
      count_nxt = count_r + NW'(1);
    end else if (rd_en && !wr_en) begin
      count_nxt = count_r - NW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= new_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// File: src/cws_back.sv
// back end: window state, command execution and the result register
`timescale 1ns / 1ps
module cws_back #(
  parameter int QUEUE_DEPTH = cws_pkg::QUEUE_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  cws_pkg::cfg_t cfg,
  input  logic          cmd_valid,
  input  cws_pkg::cmd_t cmd,
  output logic          cmd_take,
  output cws_pkg::res_t res,
  output logic          empty,
  input  logic          pop
);
  import cws_pkg::*;

  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  bst_t          state_r, state_nxt;
  logic [CW-1:0] sqc_r, sqc_nxt;
  logic [15:0]   backlog_r, backlog_nxt;
  logic [31:0]   head_r, head_nxt;
  logic [31:0]   base_r, base_nxt;
  logic [31:0]   last_sent_r, last_sent_nxt;
  logic [31:0]   stamp_r, stamp_nxt;
  logic [7:0]    cwnd_r, cwnd_nxt;
  logic [3:0]    stale_r, stale_nxt;
  logic [31:0]   page_r, page_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  res_t          res_r, res_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic          load;
  logic          slot_free;

  // send sizing
  logic [7:0]    n8;
  logic [CW-1:0] n;

  // ack evaluation
  logic          in_range;
  logic          is_stale;
  logic          timed_out;
  logic [31:0]   diff;
  logic [CW-1:0] k;
  logic [8:0]    cwnd9;
  logic [7:0]    grown;
  logic [7:0]    ack_cwnd;
  logic [3:0]    ack_stale;
  logic [2:0]    ack_ev;
  logic          ack_halved;

  assign slot_free = !out_valid_r || pop;
  assign empty     = !out_valid_r;
  assign res       = res_r;

  assign n8 = (8'(sqc_r) < cwnd_r) ? 8'(sqc_r) : cwnd_r;
  assign n  = n8[CW-1:0];

  assign in_range  = (cmd.ack_num >= base_r) && (cmd.ack_num <= last_sent_r);
  assign is_stale  = cmd.ack_num < base_r;
  assign timed_out = (cmd.now - stamp_r) > {16'd0, cfg.timeout};
  assign diff      = cmd.ack_num - base_r;
  // entries retired, capped at what is queued
  assign k         = (diff < 32'(sqc_r)) ? diff[CW-1:0] + CW'(1) : sqc_r;
  assign cwnd9     = (cwnd_r < cfg.ssthresh) ? {cwnd_r, 1'b0} : {1'b0, cwnd_r} + 9'd1;
  assign grown     = (cwnd9 > {1'b0, WIN_MAX}) ? WIN_MAX : cwnd9[7:0];

  always_comb begin
    ack_cwnd   = cwnd_r;
    ack_stale  = stale_r;
    ack_halved = 1'b0;
    if (in_range) begin
      if (timed_out) begin
        ack_cwnd = 8'd1;
        ack_ev   = EV_TIMEOUT;
      end else begin
        ack_cwnd = grown;
        ack_ev   = EV_ACK_OK;
      end
    end else if (is_stale) begin
      ack_stale = stale_r + 4'd1;
      ack_ev    = EV_STALE;
    end else begin
      ack_ev = EV_INVALID;
    end
    // stale limit check sees the updated window and count
    if (ack_stale >= cfg.dup_limit) begin
      if (ack_cwnd > 8'd1) begin
        ack_cwnd = ack_cwnd >> 1;
      end
      ack_stale  = 4'd0;
      ack_halved = 1'b1;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_IDLE: begin
        if (cmd_valid && slot_free && (cmd.op == CMD_SEND) && (n > CW'(1))) begin
          state_nxt = B_SEND;
        end
      end
      B_SEND: begin
        if (slot_free && (cnt_r == CW'(1))) begin
          state_nxt = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    cmd_take      = 1'b0;
    load          = 1'b0;
    sqc_nxt       = sqc_r;
    backlog_nxt   = backlog_r;
    head_nxt      = head_r;
    base_nxt      = base_r;
    last_sent_nxt = last_sent_r;
    stamp_nxt     = stamp_r;
    cwnd_nxt      = cwnd_r;
    stale_nxt     = stale_r;
    page_nxt      = page_r;
    cnt_nxt       = cnt_r;

    res_nxt.kind        = KIND_STATUS;
    res_nxt.page_num    = 32'd0;
    res_nxt.window      = cwnd_r;
    res_nxt.event_res   = EV_NONE;
    res_nxt.halved      = 1'b0;
    res_nxt.queue_count = 4'(sqc_r);
    res_nxt.last        = 1'b1;

    unique case (state_r)
      B_IDLE: begin
        if (cmd_valid && slot_free) begin
          cmd_take = 1'b1;
          load     = 1'b1;
          unique case (cmd.op)
            CMD_MAKE: begin
              if (sqc_r < CW'(QUEUE_DEPTH)) begin
                sqc_nxt           = sqc_r + CW'(1);
                res_nxt.event_res = EV_QUEUED;
              end else begin
                if (backlog_r < BACKLOG_MAX) begin
                  backlog_nxt = backlog_r + 16'd1;
                end
                res_nxt.event_res = EV_BACKLOG;
              end
              res_nxt.queue_count = 4'(sqc_nxt);
            end
            CMD_SEND: begin
              if (n != '0) begin
                res_nxt.kind     = KIND_PAGE;
                res_nxt.page_num = head_r;
                res_nxt.last     = (n == CW'(1));
                last_sent_nxt    = head_r + 32'(n) - 32'd1;
                stamp_nxt        = cmd.now;
                page_nxt         = head_r + 32'd1;
                cnt_nxt          = n - CW'(1);
              end
            end
            CMD_ACK: begin
              if (in_range && !timed_out) begin
                sqc_nxt  = sqc_r - k;
                head_nxt = head_r + 32'(k);
                base_nxt = cmd.ack_num + 32'd1;
              end
              cwnd_nxt            = ack_cwnd;
              stale_nxt           = ack_stale;
              res_nxt.window      = ack_cwnd;
              res_nxt.event_res   = ack_ev;
              res_nxt.halved      = ack_halved;
              res_nxt.queue_count = 4'(sqc_nxt);
            end
            CMD_NOP: ;
            default: ;
          endcase
        end
      end
      B_SEND: begin
        if (slot_free) begin
          load             = 1'b1;
          res_nxt.kind     = KIND_PAGE;
          res_nxt.page_num = page_r;
          res_nxt.last     = (cnt_r == CW'(1));
          page_nxt         = page_r + 32'd1;
          cnt_nxt          = cnt_r - CW'(1);
        end
      end
      default: ;
    endcase

    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (pop) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_nxt;
    end
    page_r <= page_nxt;
    cnt_r  <= cnt_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
      sqc_r       <= '0;
      backlog_r   <= '0;
      head_r      <= '0;
      base_r      <= '0;
      last_sent_r <= '0;
      stamp_r     <= '0;
      cwnd_r      <= 8'd1;
      stale_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      sqc_r       <= sqc_nxt;
      backlog_r   <= backlog_nxt;
      head_r      <= head_nxt;
      base_r      <= base_nxt;
      last_sent_r <= last_sent_nxt;
      stamp_r     <= stamp_nxt;
      cwnd_r      <= cwnd_nxt;
      stale_r     <= stale_nxt;
    end
  end

endmodule

// File: src/congestion_window_sender.sv
// top level of the congestion window sender
//
//   channel   handshake            payload
//   input     push / full          in_opcode, in_ack_num, in_now
//   result    pop / empty          out_kind, out_page_num, out_window, out_event_res,
//                                  out_halved, out_queue_count, out_last
//   config    psel/penable/pready  pwrite, paddr, pwdata, prdata
//
// make, ack and unused-opcode items each give one result from the back end;
// a send item gives one page result per page sent, min(queued, window), from the page sequencer,
// or a single status result when nothing is queued.
// a two-entry command queue sits between decode and execution; the result register frees
// in the cycle it is popped; a stalled result holds back the back end, and the input once the queue fills.
// reset is synchronous and clears all control and window state; no clearing pass.
`timescale 1ns / 1ps
module congestion_window_sender #(
  parameter int QUEUE_DEPTH = cws_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  output logic                       full,
  input  logic [1:0]                 in_opcode,
  input  logic [31:0]                in_ack_num,
  input  logic [31:0]                in_now,
  output logic                       empty,
  input  logic                       pop,
  output logic                       out_kind,
  output logic [31:0]                out_page_num,
  output logic [7:0]                 out_window,
  output logic [2:0]                 out_event_res,
  output logic                       out_halved,
  output logic [3:0]                 out_queue_count,
  output logic                       out_last,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [cws_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import cws_pkg::*;

  cfg_t cfg;
  cmd_t cmd;
  res_t res;
  logic cmd_valid;
  logic cmd_take;

  cws_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  cws_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .full       (full),
    .in_opcode  (in_opcode),
    .in_ack_num (in_ack_num),
    .in_now     (in_now),
    .cmd_valid  (cmd_valid),
    .cmd        (cmd),
    .cmd_take   (cmd_take)
  );

  cws_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take),
    .res       (res),
    .empty     (empty),
    .pop       (pop)
  );

  assign out_kind        = res.kind;
  assign out_page_num    = res.page_num;
  assign out_window      = res.window;
  assign out_event_res   = res.event_res;
  assign out_halved      = res.halved;
  assign out_queue_count = res.queue_count;
  assign out_last        = res.last;

endmodule
